/* hdl/folded_substring_search_sharp_s_defines.svh */
// Assertion macros shared by the folded substring search checker.
`ifndef FOLDED_SUBSTRING_SEARCH_SHARP_S_DEFINES_SVH
`define FOLDED_SUBSTRING_SEARCH_SHARP_S_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fss check failed");

// Next-cycle implication, disabled while reset is low.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fss check failed");

`endif

/* hdl/fss_pkg.sv */
// Types and constants of the folded substring search block.
package fss_pkg;

  localparam int CP_W     = 21;
  localparam int OP_W     = 2;
  localparam int OFFSET_W = 13;
  localparam int POS_W    = 12;

  localparam logic [CP_W-1:0] SHARP_S = 21'h0000DF;
  localparam logic [CP_W-1:0] LATIN_S = 21'h000073;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_NEEDLE = 2'd0,
    OP_LOAD_TEXT   = 2'd1,
    OP_SEARCH      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COMPARE,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic init;
    logic load_needle;
    logic load_text;
    logic advance;
    logic next_start;
    logic set_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic no_candidate;
    logic needle_done;
    logic h_out;
    logic unit_ok;
    logic last_start;
  } dp_status_t;

endpackage

/* hdl/fss_datapath.sv */
// Datapath: text and needle memories, lengths, search pointers and unit compare.
module fss_datapath #(
  parameter int TEXT_MAX   = 4096,
  parameter int NEEDLE_MAX = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic [fss_pkg::CP_W-1:0]      codepoint_i,
  input  logic                          restart_load_i,
  input  logic [fss_pkg::OFFSET_W-1:0]  offset_i,
  input  fss_pkg::dp_cmd_t              cmd_i,
  output fss_pkg::dp_status_t           status_o,
  output logic                          found_o,
  output logic [fss_pkg::POS_W-1:0]     position_o
);

  localparam int TW  = $clog2(TEXT_MAX);
  localparam int LW  = TW + 1;
  localparam int NW  = $clog2(NEEDLE_MAX);
  localparam int NLW = NW + 1;
  localparam int CW  = (LW > fss_pkg::OFFSET_W) ? LW : fss_pkg::OFFSET_W;
  localparam int PW  = fss_pkg::POS_W;

  logic [fss_pkg::CP_W-1:0] text_mem   [TEXT_MAX];
  logic [fss_pkg::CP_W-1:0] needle_mem [NEEDLE_MAX];

  logic [LW-1:0]  text_len_q, text_len_d;
  logic [NLW-1:0] needle_len_q, needle_len_d;
  logic           backward_q;
  logic           found_q;

  logic [TW-1:0]  i_q;
  logic [LW-1:0]  h_q;
  logic [NLW-1:0] n_q;
  logic [LW-1:0]  limit_q;

  logic                     text_we, needle_we;
  logic [TW-1:0]            text_waddr;
  logic [NW-1:0]            needle_waddr;
  logic [fss_pkg::CP_W-1:0] hc_q, hc1_q, nc_q, nc1_q;

  logic [CW-1:0] off_c, tl_c, off_m1;
  logic [TW-1:0] i_init, i_next;
  logic [LW-1:0] limit_init;
  logic [TW-1:0] h_addr, h_addr1;
  logic [NW-1:0] n_addr, n_addr1;
  logic          h1_ok, n1_ok, r_sharp, r_ss, r_eq;

  // Load path: append at the current length, or restart at address zero.
  always_comb begin
    text_len_d = text_len_q;
    text_we    = 1'b0;
    text_waddr = text_len_q[TW-1:0];
    if (cmd_i.load_text) begin
      if (restart_load_i) begin
        text_we    = 1'b1;
        text_waddr = '0;
        text_len_d = LW'(1);
      end else if (text_len_q < LW'(TEXT_MAX)) begin
        text_we    = 1'b1;
        text_len_d = text_len_q + LW'(1);
      end
    end
  end

  always_comb begin
    needle_len_d = needle_len_q;
    needle_we    = 1'b0;
    needle_waddr = needle_len_q[NW-1:0];
    if (cmd_i.load_needle) begin
      if (restart_load_i) begin
        needle_we    = 1'b1;
        needle_waddr = '0;
        needle_len_d = NLW'(1);
      end else if (needle_len_q < NLW'(NEEDLE_MAX)) begin
        needle_we    = 1'b1;
        needle_len_d = needle_len_q + NLW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len_q   <= '0;
      needle_len_q <= '0;
      backward_q   <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      text_len_q   <= text_len_d;
      needle_len_q <= needle_len_d;
      if (cfg_we_i) begin
        backward_q <= cfg_data_i;
      end
      if (cmd_i.init) begin
        found_q <= 1'b0;
      end else if (cmd_i.set_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // Memories: one write port, two registered read ports each.
  assign h_addr  = h_q[TW-1:0];
  assign h_addr1 = h_addr + TW'(1);
  assign n_addr  = n_q[NW-1:0];
  assign n_addr1 = n_addr + NW'(1);

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= codepoint_i;
    end
    hc_q  <= text_mem[h_addr];
    hc1_q <= text_mem[h_addr1];
  end

  always_ff @(posedge clk_i) begin
    if (needle_we) begin
      needle_mem[needle_waddr] <= codepoint_i;
    end
    nc_q  <= needle_mem[n_addr];
    nc1_q <= needle_mem[n_addr1];
  end

  // Search setup from the offset and the direction.
  assign off_c      = CW'(offset_i);
  assign tl_c       = CW'(text_len_q);
  assign off_m1     = off_c - CW'(1);
  assign i_init     = backward_q ? off_m1[TW-1:0] : off_c[TW-1:0];
  assign limit_init = backward_q ? off_c[LW-1:0] : text_len_q;
  assign i_next     = backward_q ? (i_q - TW'(1)) : (i_q + TW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      i_q     <= i_init;
      h_q     <= LW'(i_init);
      n_q     <= '0;
      limit_q <= limit_init;
    end else if (cmd_i.next_start) begin
      i_q <= i_next;
      h_q <= LW'(i_next);
      n_q <= '0;
    end else if (cmd_i.advance) begin
      h_q <= h_q + (r_sharp ? LW'(2) : LW'(1));
      n_q <= n_q + ((!r_sharp && r_ss) ? NLW'(2) : NLW'(1));
    end
  end

  // Unit compare: sharp s against "ss", "ss" against sharp s, else equality.
  assign h1_ok   = (h_q + LW'(1)) < text_len_q;
  assign n1_ok   = (n_q + NLW'(1)) < needle_len_q;
  assign r_sharp = (nc_q == fss_pkg::SHARP_S) && h1_ok &&
                   (hc_q == fss_pkg::LATIN_S) && (hc1_q == fss_pkg::LATIN_S);
  assign r_ss    = n1_ok && (nc_q == fss_pkg::LATIN_S) &&
                   (hc_q == fss_pkg::SHARP_S) && (nc1_q == fss_pkg::LATIN_S);
  assign r_eq    = (hc_q == nc_q);

  always_comb begin
    status_o.no_candidate = backward_q ? ((off_c == '0) || (off_c > tl_c))
                                       : (off_c >= tl_c);
    status_o.needle_done  = (n_q >= needle_len_q);
    status_o.h_out        = (h_q >= limit_q) || (h_q >= text_len_q);
    status_o.unit_ok      = r_sharp || r_ss || r_eq;
    status_o.last_start   = backward_q ? (i_q == '0)
                                       : ((LW'(i_q) + LW'(1)) >= text_len_q);
  end

  assign found_o    = found_q;
  assign position_o = found_q ? PW'(i_q) : '0;

endmodule

/* hdl/fss_ctrl.sv */
// Controller: decodes items and sequences the start-position and unit loops.
module fss_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fss_pkg::OP_W-1:0]  operation_i,
  input  fss_pkg::dp_status_t       status_i,
  output fss_pkg::dp_cmd_t          cmd_o,
  output logic                      busy_o,
  output logic                      done_o
);

  fss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != fss_pkg::ST_IDLE);
    done_o  = 1'b0;
    unique case (state_q)
      fss_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (fss_pkg::op_e'(operation_i))
            fss_pkg::OP_LOAD_NEEDLE: cmd_o.load_needle = 1'b1;
            fss_pkg::OP_LOAD_TEXT:   cmd_o.load_text = 1'b1;
            fss_pkg::OP_SEARCH: begin
              cmd_o.init = 1'b1;
              state_d    = status_i.no_candidate ? fss_pkg::ST_REPORT
                                                 : fss_pkg::ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      fss_pkg::ST_CHECK: begin
        if (status_i.needle_done) begin
          cmd_o.set_hit = 1'b1;
          state_d       = fss_pkg::ST_REPORT;
        end else if (status_i.h_out) begin
          if (status_i.last_start) begin
            state_d = fss_pkg::ST_REPORT;
          end else begin
            cmd_o.next_start = 1'b1;
          end
        end else begin
          state_d = fss_pkg::ST_COMPARE;
        end
      end
      fss_pkg::ST_COMPARE: begin
        if (status_i.unit_ok) begin
          cmd_o.advance = 1'b1;
          state_d       = fss_pkg::ST_CHECK;
        end else if (status_i.last_start) begin
          state_d = fss_pkg::ST_REPORT;
        end else begin
          cmd_o.next_start = 1'b1;
          state_d          = fss_pkg::ST_CHECK;
        end
      end
      fss_pkg::ST_REPORT: begin
        done_o  = 1'b1;
        state_d = fss_pkg::ST_IDLE;
      end
      default: state_d = fss_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/folded_substring_search_sharp_s.sv */
// Top level of the folded substring search block with sharp-s equivalence.
//
// Usage: drive one word per cycle on operation_i, codepoint_i, restart_load_i
// and offset_i; it is taken at a rising edge with start high and busy low.
// Load words (needle or text) give no result, so a stream of loads never
// raises busy. Restart_load empties the target store before the append; a
// load into a full store without restart is dropped.
// A search word raises busy until its single result has been shown.
// The result (found_o, position_o) is valid for exactly one cycle while
// done_o is high; the receiver cannot hold it off, so sample it then.
// Search steps after the accepting edge: for each start position tried,
// each unit is checked, then compared on the registered reads of the text
// and needle memories; a final check ends the try when the needle runs
// out or the next unit would start at or past the limit, then the report
// state follows; a search with no candidate start reports right after
// the accept. Busy falls after the report state.
// Forward walks up from offset, backward walks down from offset - 1; both
// stop at the first hit. The direction register is written through
// cfg_valid_i/cfg_ready_o; ready is high whenever the block is idle. Reset
// clears both lengths, the direction and the controller, not the memories.
module folded_substring_search_sharp_s #(
  parameter int TEXT_MAX   = 4096,
  parameter int NEEDLE_MAX = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [fss_pkg::OP_W-1:0]      operation_i,
  input  logic [fss_pkg::CP_W-1:0]      codepoint_i,
  input  logic                          restart_load_i,
  input  logic [fss_pkg::OFFSET_W-1:0]  offset_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [fss_pkg::POS_W-1:0]     position_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);

  fss_pkg::dp_cmd_t    cmd;
  fss_pkg::dp_status_t status;
  logic                cfg_we;

  // Take configuration only while no search is in flight.
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  fss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .done_o      (done_o)
  );

  fss_datapath #(
    .TEXT_MAX   (TEXT_MAX),
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data_i),
    .codepoint_i    (codepoint_i),
    .restart_load_i (restart_load_i),
    .offset_i       (offset_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .found_o        (found_o),
    .position_o     (position_o)
  );

endmodule

/* hdl/fss_checker.sv */
// Port-level checker for the folded substring search block, with its bind.
`include "folded_substring_search_sharp_s_defines.svh"

module fss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [fss_pkg::OP_W-1:0]      operation_i,
  input logic                          done_o,
  input logic                          found_o,
  input logic [fss_pkg::POS_W-1:0]     position_o
);

  `FSS_ASSERT_IMP(a_done_while_busy, clk_i, rst_ni, done_o, busy)
  `FSS_ASSERT_IMP(a_miss_pos_zero, clk_i, rst_ni, done_o && !found_o, position_o == '0)
  `FSS_ASSERT_NEXT(a_search_busy, clk_i, rst_ni, start && !busy && (operation_i == fss_pkg::OP_SEARCH), busy)
  `FSS_ASSERT_NEXT(a_load_no_busy, clk_i, rst_ni, start && !busy && (operation_i != fss_pkg::OP_SEARCH), !busy && !done_o)
  `FSS_ASSERT_NEXT(a_done_then_idle, clk_i, rst_ni, done_o, !busy)

endmodule

bind folded_substring_search_sharp_s fss_checker u_fss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .operation_i (operation_i),
  .done_o      (done_o),
  .found_o     (found_o),
  .position_o  (position_o)
);
